[hw/rtl/hed_pkg.sv]
// Shared types, constants and lookup functions for the HTML entity decoder.
// Used by every module of the decoder; depends on nothing else.
package hed_pkg;

    localparam int HOLD_DEPTH = 16;
    localparam int IDX_W      = $clog2(HOLD_DEPTH);
    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam int NUM_NAMES  = 7;
    localparam int NAME_MAX   = 8;
    localparam int NAME_POS_W = $clog2(NAME_MAX);
    localparam int NUM_CODES  = 8;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LZ   = 8'h7A;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UZ   = 8'h5A;

    typedef enum logic [1:0] {
        MODE_TEXT    = 2'd0,
        MODE_NAMED   = 2'd1,
        MODE_NUMERIC = 2'd2
    } t_mode;

    // Entity names, zero padded
    localparam logic [7:0] NAME_CHARS [NUM_NAMES][NAME_MAX] = '{
        '{8'h6E, 8'h62, 8'h73, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00},  // nbsp
        '{8'h62, 8'h72, 8'h76, 8'h62, 8'h61, 8'h72, 8'h00, 8'h00},  // brvbar
        '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00},  // quot
        '{8'h61, 8'h6D, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // amp
        '{8'h6C, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // lt
        '{8'h67, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // gt
        '{8'h6D, 8'h69, 8'h64, 8'h64, 8'h6F, 8'h74, 8'h00, 8'h00}   // middot
    };
    localparam int NAME_LEN [NUM_NAMES] = '{4, 6, 4, 3, 2, 2, 6};
    localparam logic [7:0] NAME_OUT [NUM_NAMES] = '{
        8'h20, 8'h7C, 8'h22, 8'h26, 8'h3C, 8'h3E, 8'h2E
    };

    localparam logic [7:0] CODE_VAL [NUM_CODES] = '{
        8'd160, 8'd166, 8'd34, 8'd38, 8'd60, 8'd62, 8'd39, 8'd183
    };
    localparam logic [7:0] CODE_OUT [NUM_CODES] = '{
        8'h20, 8'h7C, 8'h22, 8'h26, 8'h3C, 8'h3E, 8'h27, 8'h2E
    };

    typedef struct packed {
        logic       found;
        logic [7:0] ch;
    } t_hit;

    // One request from the front to the back: store a held byte, then emit
    // the held bytes or a known character, then an optional tail byte.
    typedef struct packed {
        logic             store;
        logic [IDX_W-1:0] store_idx;
        logic [7:0]       store_byte;
        logic             flush;
        logic [CNT_W-1:0] flush_cnt;
        logic             known;
        logic [7:0]       known_ch;
        logic             tail;
        logic [7:0]       tail_byte;
        logic             last;
    } t_cmd;

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= CH_LA) && (b <= CH_LZ)) || ((b >= CH_UA) && (b <= CH_UZ));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // Narrow the name candidates by the letter at position pos of the name
    function automatic logic [NUM_NAMES-1:0] name_step(input logic [NUM_NAMES-1:0] mask,
                                                       input logic [CNT_W-1:0] pos,
                                                       input logic [7:0] b);
        logic [NUM_NAMES-1:0] m;
        for (int i = 0; i < NUM_NAMES; i++) begin
            m[i] = mask[i] && (pos < CNT_W'(NAME_MAX)) &&
                   (NAME_CHARS[i][pos[NAME_POS_W-1:0]] == b);
        end
        return m;
    endfunction

    // count includes the leading ampersand
    function automatic t_hit name_lookup(input logic [NUM_NAMES-1:0] mask,
                                         input logic [CNT_W-1:0] count);
        t_hit h;
        h = '0;
        for (int i = 0; i < NUM_NAMES; i++) begin
            if (mask[i] && (count == CNT_W'(NAME_LEN[i] + 1))) begin
                h.found = 1'b1;
                h.ch    = NAME_OUT[i];
            end
        end
        return h;
    endfunction

    function automatic t_hit code_lookup(input logic [7:0] value);
        t_hit h;
        h = '0;
        for (int i = 0; i < NUM_CODES; i++) begin
            if (CODE_VAL[i] == value) begin
                h.found = 1'b1;
                h.ch    = CODE_OUT[i];
            end
        end
        return h;
    endfunction

    // value * 10 + digit, saturating at 255
    function automatic logic [7:0] dec_step(input logic [7:0] value, input logic [7:0] b);
        logic [11:0] v;
        v = 12'(value) * 12'd10 + 12'(b[3:0]);
        return (v > 12'd255) ? 8'hFF : v[7:0];
    endfunction

endpackage

[hw/rtl/hed_front.sv]
// Front part of the HTML entity decoder: accepts bytes, tracks the entity
// parse state and issues at most one request per byte into the queue. Uses hed_pkg.
module hed_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic          o_ready,
    input  logic          i_q_full,
    output logic          o_push,
    output hed_pkg::t_cmd o_cmd
);

    hed_pkg::t_mode                    r_mode,  n_mode;
    logic [hed_pkg::CNT_W-1:0]         r_count, n_count;
    logic [7:0]                        r_value, n_value;
    logic [hed_pkg::NUM_NAMES-1:0]     r_match, n_match;

    logic                              accept;
    logic                              in_named, in_numeric;
    logic                              letter, digit, is_semi, is_amp, is_hash;
    logic                              is_take, room, t_numeric;
    logic [hed_pkg::CNT_W-1:0]         t_count;
    logic [7:0]                        t_value;
    logic [hed_pkg::NUM_NAMES-1:0]     t_match;
    hed_pkg::t_hit                     cur_hit, take_hit;
    logic                              start, clear;
    hed_pkg::t_cmd                     cmd;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        in_named   = 1'b0;
        in_numeric = 1'b0;
        unique case (r_mode)
            hed_pkg::MODE_NAMED:   in_named   = 1'b1;
            hed_pkg::MODE_NUMERIC: in_numeric = 1'b1;
            default: begin
                in_named   = 1'b0;
                in_numeric = 1'b0;
            end
        endcase
    end

    always_comb begin
        letter  = hed_pkg::is_letter(i_byte);
        digit   = hed_pkg::is_digit(i_byte);
        is_semi = (i_byte == hed_pkg::CH_SEMI);
        is_amp  = (i_byte == hed_pkg::CH_AMP);
        is_hash = (i_byte == hed_pkg::CH_HASH);
        is_take = (in_named && (r_count == hed_pkg::CNT_W'(1)) && is_hash) ||
                  (in_named && letter) || (in_numeric && digit);
        room    = r_count < hed_pkg::CNT_W'(hed_pkg::HOLD_DEPTH);

        // State after the byte joins the entity
        t_numeric = in_numeric || (in_named && is_hash);
        t_count   = r_count + hed_pkg::CNT_W'(1);
        t_value   = in_numeric ? hed_pkg::dec_step(r_value, i_byte) : r_value;
        t_match   = hed_pkg::name_step(r_match, r_count - hed_pkg::CNT_W'(1), i_byte);

        cur_hit  = in_numeric ? hed_pkg::code_lookup(r_value)
                              : hed_pkg::name_lookup(r_match, r_count);
        take_hit = t_numeric ? hed_pkg::code_lookup(t_value)
                             : hed_pkg::name_lookup(t_match, t_count);
    end

    always_comb begin
        cmd      = '0;
        cmd.last = i_last;
        start    = 1'b0;
        clear    = 1'b0;
        o_push   = 1'b0;
        n_mode   = r_mode;
        n_count  = r_count;
        n_value  = r_value;
        n_match  = r_match;

        if (accept) begin
            if (!in_named && !in_numeric) begin
                if (is_amp && !i_last) begin
                    start = 1'b1;
                end else begin
                    cmd.tail      = 1'b1;
                    cmd.tail_byte = i_byte;
                    clear         = 1'b1;
                end
            end else if (is_take && room) begin
                cmd.store      = 1'b1;
                cmd.store_idx  = r_count[hed_pkg::IDX_W-1:0];
                cmd.store_byte = i_byte;
                if (i_last) begin
                    // End of string closes the entity with this byte in it
                    if (take_hit.found) begin
                        cmd.known    = 1'b1;
                        cmd.known_ch = take_hit.ch;
                    end else begin
                        cmd.flush     = 1'b1;
                        cmd.flush_cnt = t_count;
                    end
                    clear = 1'b1;
                end else begin
                    n_mode  = t_numeric ? hed_pkg::MODE_NUMERIC : hed_pkg::MODE_NAMED;
                    n_count = t_count;
                    n_value = t_value;
                    n_match = t_match;
                end
            end else if (is_take) begin
                // Buffer full: flush verbatim and pass the byte through
                cmd.flush     = 1'b1;
                cmd.flush_cnt = r_count;
                cmd.tail      = 1'b1;
                cmd.tail_byte = i_byte;
                clear         = 1'b1;
            end else begin
                if (cur_hit.found) begin
                    cmd.known    = 1'b1;
                    cmd.known_ch = cur_hit.ch;
                end else begin
                    cmd.flush     = 1'b1;
                    cmd.flush_cnt = r_count;
                end
                if (is_semi) begin
                    cmd.tail      = !cur_hit.found;
                    cmd.tail_byte = hed_pkg::CH_SEMI;
                    clear         = 1'b1;
                end else if (is_amp && !i_last) begin
                    start = 1'b1;
                end else begin
                    cmd.tail      = 1'b1;
                    cmd.tail_byte = i_byte;
                    clear         = 1'b1;
                end
            end
            o_push = cmd.store || cmd.flush || cmd.known || cmd.tail;
        end

        if (start) begin
            n_mode  = hed_pkg::MODE_NAMED;
            n_count = hed_pkg::CNT_W'(1);
            n_value = '0;
            n_match = '1;
        end else if (clear) begin
            n_mode  = hed_pkg::MODE_TEXT;
            n_count = '0;
            n_value = '0;
            n_match = '1;
        end
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= hed_pkg::MODE_TEXT;
            r_count <= '0;
            r_value <= '0;
            r_match <= '1;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_value <= n_value;
            r_match <= n_match;
        end
    end

endmodule

[hw/rtl/hed_cmd_queue.sv]
// Short request queue between the front and back parts of the decoder.
// Register based FIFO of hed_pkg::t_cmd entries; uses hed_pkg.
module hed_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hed_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output hed_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    hed_pkg::t_cmd               r_mem [hed_pkg::Q_DEPTH];
    logic [hed_pkg::Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [hed_pkg::Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [hed_pkg::Q_CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == hed_pkg::Q_CNT_W'(hed_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + hed_pkg::Q_PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + hed_pkg::Q_PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + hed_pkg::Q_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - hed_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[hw/rtl/hed_back.sv]
// Back part of the HTML entity decoder: carries out queued requests, owns
// the hold buffer memory and the output register. Uses hed_pkg.
module hed_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  hed_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_last
);

    logic [7:0]                r_hold [hed_pkg::HOLD_DEPTH];
    logic [7:0]                r_rd_data;

    hed_pkg::t_cmd             r_cmd, n_cmd;
    logic                      r_busy, n_busy;
    logic                      r_fl, n_fl;
    logic                      r_kn, n_kn;
    logic                      r_tl, n_tl;
    logic [hed_pkg::IDX_W-1:0] r_idx, n_idx;

    logic                      r_out_valid, n_out_valid;
    logic [7:0]                r_out_byte,  n_out_byte;
    logic                      r_out_last,  n_out_last;

    logic                      out_free, emit, fl_done, final_out, done;
    logic [7:0]                sel;

    always_comb begin
        out_free = !r_out_valid || i_ready;
        emit     = r_busy && out_free;
        fl_done  = (hed_pkg::CNT_W'(r_idx) + hed_pkg::CNT_W'(1)) == r_cmd.flush_cnt;

        // Held bytes first, then the known character, then the tail byte
        priority if (r_fl) begin
            sel       = (r_idx == '0) ? hed_pkg::CH_AMP : r_rd_data;
            final_out = fl_done && !r_kn && !r_tl;
        end else if (r_kn) begin
            sel       = r_cmd.known_ch;
            final_out = !r_tl;
        end else begin
            sel       = r_cmd.tail_byte;
            final_out = 1'b1;
        end

        done  = emit && final_out;
        o_pop = i_cmd_valid && (!r_busy || done);

        n_cmd  = r_cmd;
        n_busy = r_busy;
        n_fl   = r_fl;
        n_kn   = r_kn;
        n_tl   = r_tl;
        n_idx  = r_idx;

        if (emit) begin
            priority if (r_fl) begin
                n_fl  = !fl_done;
                n_idx = fl_done ? '0 : r_idx + hed_pkg::IDX_W'(1);
            end else if (r_kn) begin
                n_kn = 1'b0;
            end else begin
                n_tl = 1'b0;
            end
        end

        if (o_pop) begin
            n_cmd  = i_cmd;
            n_fl   = i_cmd.flush;
            n_kn   = i_cmd.known;
            n_tl   = i_cmd.tail;
            n_idx  = '0;
            n_busy = i_cmd.flush || i_cmd.known || i_cmd.tail;
        end else if (done) begin
            n_busy = 1'b0;
        end

        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = sel;
            n_out_last  = r_cmd.last && final_out;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_fl        <= 1'b0;
            r_kn        <= 1'b0;
            r_tl        <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_fl        <= n_fl;
            r_kn        <= n_kn;
            r_tl        <= n_tl;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    // Hold buffer: written when a request is taken, read one entry ahead of
    // the flush index; entry zero is never written, the ampersand replaces it
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.store) begin
            r_hold[i_cmd.store_idx] <= i_cmd.store_byte;
        end
        r_rd_data <= r_hold[n_idx];
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

endmodule

[hw/rtl/html_entity_decoder_top.sv]
// Top level of the HTML entity decoder: front, request queue and back.
// Depends on hed_pkg, hed_front, hed_cmd_queue and hed_back.
//
// Usage:
//   Slave channel (i_s_*) takes one escaped text byte per request, tlast
//   marking the final byte of a string. Master channel (o_m_*) delivers the
//   unescaped bytes, tlast on the final byte produced for a string.
//   Entities (&name; or &#digits;) are collected until they close; a known
//   one becomes one byte, anything else is replayed byte for byte.
// Flow:
//   A result passes the request queue, the back part's request register
//   and the output register on its way to o_m_*. Plain bytes sustain one
//   per cycle while i_m_tready stays high. The back part emits one output
//   byte per cycle while its output is free; in a verbatim flush the front
//   keeps taking bytes until the four-entry queue fills and o_s_tready drops.
// Reset:
//   Synchronous, active low. Clears the parse state, the queue and the
//   output register; the hold buffer keeps its contents.
// Stall:
//   While i_m_tready is low the output byte holds, the back part waits and
//   the queue absorbs up to four more requests.
module html_entity_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast
);

    hed_pkg::t_cmd push_cmd;
    hed_pkg::t_cmd head_cmd;
    logic          push, pop, q_full, q_empty;

    hed_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_ready  (o_s_tready),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    hed_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty)
    );

    hed_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!q_empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_byte      (o_m_tdata),
        .o_last      (o_m_tlast)
    );

endmodule

[hw/rtl/hed_checker.sv]
// Port level checks for the HTML entity decoder, bound to the top level.
// Depends on html_entity_decoder_top only through its ports.
module hed_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [7:0] i_s_tdata,
    input logic       i_s_tlast,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready right after reset");

endmodule

bind html_entity_decoder_top hed_checker u_hed_checker (.*);

[verif/tb_html_entity_decoder_top.sv]
// Self-checking testbench for html_entity_decoder_top: escaped strings in, decoded bytes out.
// Predicts every output byte from its own decoder model; depends on hed_pkg and the RTL.
module tb_html_entity_decoder_top;

    localparam int CALM_TAIL   = 40;
    localparam int RANDOM_ITEMS = 260;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_text_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'h00;   // [7:0] in_byte
    logic       i_s_tlast = 1'b0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;           // [7:0] out_byte
    logic       o_m_tlast;

    html_entity_decoder_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_text_byte pending_text[$];
    t_text_byte decoded_bytes[$];
    int errors      = 0;
    int bytes_sent  = 0;
    int bytes_seen  = 0;
    int strings_cnt = 0;

    // decoder state
    hed_pkg::t_mode mode = hed_pkg::MODE_TEXT;
    logic [7:0]     held [hed_pkg::HOLD_DEPTH];
    int             held_n = 0;
    int             dec_val = 0;

    function automatic bit is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_num(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic int name_char(input string nm);
        case (nm)
            "nbsp":   return 8'h20;
            "brvbar": return 8'h7C;
            "quot":   return 8'h22;
            "amp":    return 8'h26;
            "lt":     return 8'h3C;
            "gt":     return 8'h3E;
            "middot": return 8'h2E;
            default:  return -1;
        endcase
    endfunction

    function automatic int code_char(input int v);
        case (v)
            160:     return 8'h20;
            166:     return 8'h7C;
            34:      return 8'h22;
            38:      return 8'h26;
            60:      return 8'h3C;
            62:      return 8'h3E;
            39:      return 8'h27;
            183:     return 8'h2E;
            default: return -1;
        endcase
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        t_text_byte t;
        t.ch   = b;
        t.last = 1'b0;
        decoded_bytes = {decoded_bytes, t};
    endtask

    task automatic flush_held();
        for (int i = 0; i < held_n; i++) emit_byte(held[i]);
    endtask

    task automatic clear_entity();
        mode    = hed_pkg::MODE_TEXT;
        held_n  = 0;
        dec_val = 0;
    endtask

    // known entity -> one byte; otherwise replay the held bytes (and the semicolon)
    task automatic close_entity(input bit semi);
        int    hit;
        string nm;
        hit = -1;
        if (mode == hed_pkg::MODE_NUMERIC) begin
            hit = code_char(dec_val);
        end else if (held_n >= 1) begin
            nm = "";
            for (int i = 1; i < held_n; i++) nm = $sformatf("%s%c", nm, held[i]);
            hit = name_char(nm);
        end
        if (hit >= 0) begin
            emit_byte(hit[7:0]);
        end else begin
            flush_held();
            if (semi) emit_byte(hed_pkg::CH_SEMI);
        end
        clear_entity();
    endtask

    task automatic plain_byte(input logic [7:0] b, input bit last);
        if (b == hed_pkg::CH_AMP) begin
            clear_entity();
            held[0] = b;
            held_n  = 1;
            mode    = hed_pkg::MODE_NAMED;
            if (last) close_entity(1'b0);
        end else begin
            emit_byte(b);
        end
    endtask

    task automatic take_byte(input logic [7:0] b, input bit last);
        if (held_n < hed_pkg::HOLD_DEPTH) begin
            held[held_n] = b;
            held_n++;
            if (last) close_entity(1'b0);
        end else begin
            flush_held();
            clear_entity();
            emit_byte(b);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input bit last);
        int first;
        first = decoded_bytes.size();
        case (mode)
            hed_pkg::MODE_NAMED: begin
                if (held_n == 1 && b == hed_pkg::CH_HASH) begin
                    mode = hed_pkg::MODE_NUMERIC;
                    take_byte(b, last);
                end else if (is_alpha(b)) begin
                    take_byte(b, last);
                end else if (b == hed_pkg::CH_SEMI) begin
                    close_entity(1'b1);
                end else begin
                    close_entity(1'b0);
                    plain_byte(b, last);
                end
            end
            hed_pkg::MODE_NUMERIC: begin
                if (is_num(b)) begin
                    dec_val = dec_val * 10 + int'(b - "0");
                    if (dec_val > 255) dec_val = 255;
                    take_byte(b, last);
                end else if (b == hed_pkg::CH_SEMI) begin
                    close_entity(1'b1);
                end else begin
                    close_entity(1'b0);
                    plain_byte(b, last);
                end
            end
            default: begin
                mode = hed_pkg::MODE_TEXT;
                plain_byte(b, last);
            end
        endcase
        if (last) begin
            clear_entity();
            if (decoded_bytes.size() > first)
                decoded_bytes[decoded_bytes.size() - 1].last = 1'b1;
        end
    endtask

    // stimulus helpers
    task automatic add_byte(input logic [7:0] b);
        t_text_byte t;
        t.ch   = b;
        t.last = 1'b0;
        pending_text = {pending_text, t};
        bytes_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic end_string();
        if (pending_text.size() > 0) pending_text[pending_text.size() - 1].last = 1'b1;
        strings_cnt++;
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'($urandom_range(0, 25));
        return ($urandom_range(0, 3) == 0) ? c + "A" : c + "a";
    endfunction

    task automatic add_letters(input int n);
        for (int i = 0; i < n; i++) add_byte(rand_letter());
    endtask

    task automatic add_digits(input int n);
        for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 9)) + "0");
    endtask

    task automatic maybe_semi();
        if ($urandom_range(0, 1) == 0) add_byte(hed_pkg::CH_SEMI);
    endtask

    task automatic add_random_string();
        string names [7];
        int    codes [8];
        string nm;
        int    segs;
        names = '{"nbsp", "brvbar", "quot", "amp", "lt", "gt", "middot"};
        codes = '{160, 166, 34, 38, 60, 62, 39, 183};
        segs  = $urandom_range(1, 10);
        for (int s = 0; s < segs; s++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    for (int i = $urandom_range(1, 4); i > 0; i--)
                        add_byte(8'($urandom_range(0, 255)));
                end
                2, 3: begin
                    nm = names[$urandom_range(0, 6)];
                    // corrupt one letter now and then
                    if ($urandom_range(0, 5) == 0) nm[$urandom_range(0, nm.len() - 1)] = rand_letter();
                    add_byte(hed_pkg::CH_AMP);
                    add_text(nm);
                    maybe_semi();
                end
                4: begin
                    add_text("&#");
                    if ($urandom_range(0, 3) == 0) add_byte("0");
                    add_text($sformatf("%0d", codes[$urandom_range(0, 7)]));
                    maybe_semi();
                end
                5: begin
                    add_text("&#");
                    add_digits($urandom_range(0, 5));
                    maybe_semi();
                end
                6: begin
                    add_byte(hed_pkg::CH_AMP);
                    add_letters($urandom_range(0, 8));
                    maybe_semi();
                end
                7: begin
                    // run up to or past the hold buffer
                    if ($urandom_range(0, 1) == 0) begin
                        add_byte(hed_pkg::CH_AMP);
                        add_letters($urandom_range(14, 17));
                    end else begin
                        add_text("&#");
                        add_digits($urandom_range(13, 16));
                    end
                    maybe_semi();
                end
                8: begin
                    add_byte(hed_pkg::CH_AMP);
                    case ($urandom_range(0, 2))
                        0: add_byte(hed_pkg::CH_AMP);
                        1: add_byte(hed_pkg::CH_SEMI);
                        default: add_byte(8'($urandom_range(128, 255)));
                    endcase
                end
                default: add_byte(8'($urandom_range(0, 255)));
            endcase
        end
        end_string();
    endtask

    // driver
    int gap_left = 0;
    int run_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'h00;
            i_s_tlast  <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                decode_byte(pending_text[0].ch, pending_text[0].last);
                void'(pending_text.pop_front());
            end
            // hold a request that has not been taken
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    if (gap_left == 0) run_left = $urandom_range(0, 40);
                    i_s_tvalid <= 1'b0;
                end else if (pending_text.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                end else if (run_left == 0 && pending_text.size() >= CALM_TAIL &&
                             $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 15);
                    i_s_tvalid <= 1'b0;
                end else begin
                    if (run_left > 0) run_left--;
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pending_text[0].ch;
                    i_s_tlast  <= pending_text[0].last;
                end
            end
        end
    end

    // monitor
    int stall_left = 0;
    int flow_left  = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                bytes_seen++;
                if (decoded_bytes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual byte %h last %b",
                             $time, o_m_tdata, o_m_tlast);
                    errors++;
                end else begin
                    if (o_m_tdata !== decoded_bytes[0].ch) begin
                        $display("%0t: out_byte mismatch, expected %h actual %h",
                                 $time, decoded_bytes[0].ch, o_m_tdata);
                        errors++;
                    end
                    if (o_m_tlast !== decoded_bytes[0].last) begin
                        $display("%0t: out_last mismatch, expected %b actual %b",
                                 $time, decoded_bytes[0].last, o_m_tlast);
                        errors++;
                    end
                    void'(decoded_bytes.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) flow_left = $urandom_range(0, 40);
                i_m_tready <= 1'b0;
            end else if (flow_left == 0 && pending_text.size() >= CALM_TAIL &&
                         $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 15);
                i_m_tready <= 1'b0;
            end else begin
                if (flow_left > 0) flow_left--;
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        // directed: named, numeric, bare ampersand, empty numeric, saturation,
        // non-ASCII bytes and an entity cut off by the end of the string
        add_text("&lt;");
        add_text("&#183");
        add_text("&;");
        add_text("&#;");
        add_text("&#999");
        add_text("x");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("&");
        end_string();
        while (bytes_sent < RANDOM_ITEMS) add_random_string();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_text.size() != 0 || decoded_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (decoded_bytes.size() != 0) begin
            $display("%0t: missing results, expected %0d more, actual 0",
                     $time, decoded_bytes.size());
            errors++;
        end
        $display("sent %0d bytes in %0d strings with random stalls on both sides,",
                 bytes_sent, strings_cnt);
        $display("checked %0d decoded bytes, %0d errors", bytes_seen, errors);
        if (errors == 0) begin
            $display("tb_html_entity_decoder_top: clean");
        end else begin
            $display("tb_html_entity_decoder_top: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("tb_html_entity_decoder_top: errors");
        $finish;
    end

endmodule

[files.f]
hw/rtl/hed_pkg.sv
hw/rtl/hed_front.sv
hw/rtl/hed_cmd_queue.sv
hw/rtl/hed_back.sv
hw/rtl/html_entity_decoder_top.sv
hw/rtl/hed_checker.sv
verif/tb_html_entity_decoder_top.sv
